// File: rtl/fqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqs_pkg
// Types, codes and constants shared by the search FIFO and its checker.
// ----------------------------------------------------------------------------
package fqs_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_DEQUEUE = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_SEARCH  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_READ,
		S_RESP
	} state_t;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage
`default_nettype wire

// File: rtl/fifo_queue_with_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_queue_with_search
// Bounded ring FIFO of signed 32-bit words with enqueue, dequeue, clear and
// a linear search from the head.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low, and exactly one
// result comes back later as a single-cycle done strobe, which the receiver
// must take as it comes. Enqueue, dequeue and clear update the pointers, and
// enqueue writes the entry store, at the accepting edge; busy stays high
// through S_READ, for the registered read of the head and rear entries, and
// S_RESP, to load the result. A search of a queue holding n words reads one
// stored word per cycle through a single read port, compares it with one
// shared comparator in the cycle after the read, holds busy high through
// its compares and stops early at the first match. done shows in a cycle
// where busy is already low, so the next start may be given alongside.
module fifo_queue_with_search (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [1:0]                       operation,
	input  wire logic signed [fqs_pkg::DATA_W-1:0] value,
	output logic                                  busy,
	output logic                                  done,
	output logic [1:0]                            status,
	output logic [fqs_pkg::CNT_W-1:0]             fill_count,
	output logic signed [fqs_pkg::DATA_W-1:0]     head_value,
	output logic signed [fqs_pkg::DATA_W-1:0]     rear_value,
	output logic [fqs_pkg::CNT_W-1:0]             found_position
);

	fqs_pkg::state_t  state_q, state_d;
	fqs_pkg::op_t     op_in;
	fqs_pkg::status_t status_q, acc_status;

	logic [fqs_pkg::DATA_W-1:0] mem [fqs_pkg::DEPTH];

	logic [fqs_pkg::PTR_W-1:0]  head_q, tail_q, srch_ptr_q, rear_ptr, rd_addr_a;
	logic [fqs_pkg::CNT_W-1:0]  count_q, issue_cnt_q, found_q, cmp_pos_s1;
	logic                       cmp_vld_s1, done_q;
	logic [fqs_pkg::DATA_W-1:0] val_q, rd_a_q, rd_b_q;

	logic accept, is_full, is_empty;
	logic search_act, issue, hit, last_cmp, load_res;

	assign op_in    = fqs_pkg::op_t'(operation);
	assign is_full  = (count_q == fqs_pkg::CNT_W'(fqs_pkg::DEPTH));
	assign is_empty = (count_q == '0);
	assign accept   = start && (state_q == fqs_pkg::S_IDLE);
	assign rear_ptr = (tail_q == '0) ? fqs_pkg::PTR_W'(fqs_pkg::DEPTH - 1) : tail_q - 1'b1;

	// search pipeline: issue a read, compare the word in the cycle after
	assign issue     = search_act && (issue_cnt_q < count_q);
	assign hit       = search_act && cmp_vld_s1 && (rd_a_q == val_q);
	assign last_cmp  = search_act && cmp_vld_s1 && (cmp_pos_s1 == count_q);
	assign rd_addr_a = search_act ? srch_ptr_q : head_q;

	always_comb begin
		acc_status = fqs_pkg::STAT_OK;
		case (op_in)
			fqs_pkg::OP_ENQUEUE: begin
				if (is_full) acc_status = fqs_pkg::STAT_FULL;
			end
			fqs_pkg::OP_DEQUEUE, fqs_pkg::OP_CLEAR, fqs_pkg::OP_SEARCH: begin
				if (is_empty) acc_status = fqs_pkg::STAT_EMPTY;
			end
			default: acc_status = fqs_pkg::STAT_OK;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fqs_pkg::S_IDLE: begin
				if (start) begin
					if (op_in == fqs_pkg::OP_SEARCH && !is_empty) state_d = fqs_pkg::S_SEARCH;
					else state_d = fqs_pkg::S_READ;
				end
			end
			fqs_pkg::S_SEARCH: begin
				if (hit || last_cmp) state_d = fqs_pkg::S_READ;
			end
			fqs_pkg::S_READ: state_d = fqs_pkg::S_RESP;
			fqs_pkg::S_RESP: state_d = fqs_pkg::S_IDLE;
			default:         state_d = fqs_pkg::S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy       = 1'b1;
		search_act = 1'b0;
		load_res   = 1'b0;
		case (state_q)
			fqs_pkg::S_IDLE:   busy = 1'b0;
			fqs_pkg::S_SEARCH: search_act = 1'b1;
			fqs_pkg::S_READ:   busy = 1'b1;
			fqs_pkg::S_RESP:   load_res = 1'b1;
			default:           busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fqs_pkg::S_IDLE;
			status_q    <= fqs_pkg::STAT_OK;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			srch_ptr_q  <= '0;
			issue_cnt_q <= '0;
			found_q     <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_pos_s1  <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= load_res;
			if (accept) begin
				status_q    <= acc_status;
				srch_ptr_q  <= head_q;
				issue_cnt_q <= '0;
				found_q     <= '0;
				cmp_vld_s1  <= 1'b0;
				case (op_in)
					fqs_pkg::OP_ENQUEUE: begin
						if (!is_full) begin
							tail_q  <= fqs_pkg::ring_next(tail_q);
							count_q <= count_q + 1'b1;
						end
					end
					fqs_pkg::OP_DEQUEUE: begin
						if (!is_empty) begin
							head_q  <= fqs_pkg::ring_next(head_q);
							count_q <= count_q - 1'b1;
						end
					end
					fqs_pkg::OP_CLEAR: begin
						head_q  <= '0;
						tail_q  <= '0;
						count_q <= '0;
					end
					fqs_pkg::OP_SEARCH: begin
						head_q <= head_q;
					end
					default: begin
						head_q <= head_q;
					end
				endcase
			end else if (search_act) begin
				cmp_vld_s1 <= issue;
				cmp_pos_s1 <= issue_cnt_q + 1'b1;
				if (issue) begin
					srch_ptr_q  <= fqs_pkg::ring_next(srch_ptr_q);
					issue_cnt_q <= issue_cnt_q + 1'b1;
				end
				if (hit) found_q <= cmp_pos_s1;
			end
		end
	end

	// entry store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (accept && op_in == fqs_pkg::OP_ENQUEUE && !is_full) mem[tail_q] <= value;
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rear_ptr];
	end

	always_ff @(posedge clk) begin
		if (accept) val_q <= value;
		if (load_res) begin
			status         <= status_q;
			fill_count     <= count_q;
			head_value     <= is_empty ? '0 : rd_a_q;
			rear_value     <= is_empty ? '0 : rd_b_q;
			found_position <= found_q;
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

// File: rtl/fqs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqs_checker
// Port-level checks on the search FIFO, bound to its top level.
// ----------------------------------------------------------------------------
module fqs_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             start,
	input wire logic                             busy,
	input wire logic                             done,
	input wire logic [1:0]                       status,
	input wire logic [fqs_pkg::CNT_W-1:0]        fill_count,
	input wire logic signed [fqs_pkg::DATA_W-1:0] head_value,
	input wire logic signed [fqs_pkg::DATA_W-1:0] rear_value,
	input wire logic [fqs_pkg::CNT_W-1:0]        found_position
);

	// an accepted word keeps the block busy for the next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low after an accepted word");

	// result word shows only once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && !$past(done))
		else $error("result word while busy or held");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> fill_count <= fqs_pkg::CNT_W'(fqs_pkg::DEPTH))
		else $error("fill count beyond depth");

	// an empty queue reports nothing held
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == 2'(fqs_pkg::STAT_EMPTY) |->
			fill_count == '0 && head_value == '0 && rear_value == '0 && found_position == '0)
		else $error("empty result carries data");

	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && found_position != '0 |->
			found_position <= fill_count && status == 2'(fqs_pkg::STAT_OK))
		else $error("match position outside the queue");

endmodule

bind fifo_queue_with_search fqs_checker u_fqs_checker (.*);
`default_nettype wire
